>>> hdl/ihf_pkg.sv
// isotherm height finder: shared constants and width helpers
// no dependencies; used by every module of the block
`default_nettype none

package ihf_pkg;

    localparam int TEMP_BITS_DEF   = 16;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int TARGET_BITS     = 14;
    localparam int MISSING_BITS    = 16;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 3;
    localparam int QUEUE_DEPTH     = 2;

    // register index, taken from paddr[2]
    localparam logic REG_TARGET  = 1'b0;
    localparam logic REG_MISSING = 1'b1;

    // common compare width for temperatures, target and missing code
    function automatic int ext_bits(input int temp_bits);
        int w;
        w = (temp_bits > MISSING_BITS) ? temp_bits : MISSING_BITS;
        return w;
    endfunction

    // job word: found, hlo, tdiff, dh, dt
    function automatic int job_bits(input int temp_bits, input int height_bits);
        int w;
        w = 1 + height_bits + (ext_bits(temp_bits) + 1) + (height_bits + 1) + (temp_bits + 1);
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/isotherm_height_finder.sv
// isotherm height finder top level: config registers, front end, job queue, back end
// depends on ihf_pkg, ihf_front, ihf_queue, ihf_back
//
//  port group   signals                                   role
//  ----------   ---------------------------------------   --------------------------------
//  in           in_valid/in_ready, level_temp,             one level sample, bottom first
//               level_height, last_level
//  out          out_valid/out_ready, isotherm_height,      one height per column
//               crossing_found
//  apb          psel/penable/pwrite/paddr/pwdata/          target_temp at 0, missing_temp at 4
//               prdata/pready
//
// the front end takes one sample per cycle while the job queue has room
// a clamped column goes straight to the back-end output register; an interpolated one passes
// through multiply, sign prep, one quotient bit per cycle and the final add
// back-end throughput therefore sets the rate for short columns with a crossing
// rst_n clears all control state; config registers return to 0 and -32768
// a stalled output holds the back end; a full queue drops in_ready
`default_nettype none

module isotherm_height_finder #(
    parameter int TEMP_BITS   = ihf_pkg::TEMP_BITS_DEF,
    parameter int HEIGHT_BITS = ihf_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [TEMP_BITS-1:0]           level_temp,
    input  wire logic [HEIGHT_BITS-1:0]                level_height,
    input  wire logic                                  last_level,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [HEIGHT_BITS-1:0]                     isotherm_height,
    output logic                                       crossing_found,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ihf_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [ihf_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ihf_pkg::APB_DATA_BITS-1:0]          prdata,
    output logic                                       pready
);

    localparam int JW = ihf_pkg::job_bits(TEMP_BITS, HEIGHT_BITS);
    localparam int TB = ihf_pkg::TARGET_BITS;
    localparam int MB = ihf_pkg::MISSING_BITS;
    localparam int DB = ihf_pkg::APB_DATA_BITS;

    logic signed [TB-1:0] target_reg;
    logic signed [MB-1:0] missing_reg;
    logic                 cfg_wr;

    logic                 push_valid, push_ready;
    logic [JW-1:0]        push_data;
    logic                 pop_valid, pop_ready;
    logic [JW-1:0]        pop_data;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            missing_reg <= MB'(-(2 ** (MB - 1)));
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ihf_pkg::REG_TARGET)
            begin
                target_reg <= pwdata[TB-1:0];
            end
            else
            begin
                missing_reg <= pwdata[MB-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == ihf_pkg::REG_MISSING) ? DB'(missing_reg) : DB'(target_reg);

    ihf_front #(
        .TEMP_BITS   (TEMP_BITS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_temp  (target_reg),
        .missing_temp (missing_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .level_temp   (level_temp),
        .level_height (level_height),
        .last_level   (last_level),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job_data     (push_data)
    );

    ihf_queue #(
        .WIDTH (JW),
        .DEPTH (ihf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ihf_back #(
        .TEMP_BITS   (TEMP_BITS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (pop_valid),
        .job_ready       (pop_ready),
        .job_data        (pop_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .isotherm_height (isotherm_height),
        .crossing_found  (crossing_found)
    );

endmodule

`default_nettype wire

>>> hdl/ihf_front.sv
// front end: per-sample column tracking, crossing detection, one job per column
// depends on ihf_pkg
`default_nettype none

module ihf_front #(
    parameter int TEMP_BITS   = ihf_pkg::TEMP_BITS_DEF,
    parameter int HEIGHT_BITS = ihf_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic signed [ihf_pkg::TARGET_BITS-1:0]  target_temp,
    input  wire logic signed [ihf_pkg::MISSING_BITS-1:0] missing_temp,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [TEMP_BITS-1:0]             level_temp,
    input  wire logic [HEIGHT_BITS-1:0]                  level_height,
    input  wire logic                                    last_level,
    output logic                                         job_valid,
    input  wire logic                                    job_ready,
    output logic [ihf_pkg::job_bits(TEMP_BITS, HEIGHT_BITS)-1:0] job_data
);

    localparam int XW = ihf_pkg::ext_bits(TEMP_BITS);
    localparam int DW = XW + 1;
    localparam int JW = ihf_pkg::job_bits(TEMP_BITS, HEIGHT_BITS);

    logic                          first_reg, first_next;
    logic signed [TEMP_BITS-1:0]   prev_temp_reg;
    logic [HEIGHT_BITS-1:0]        prev_height_reg;
    logic [HEIGHT_BITS-1:0]        bot_height_reg, bot_height_next;
    logic signed [XW-1:0]          bot_temp_reg, bot_temp_next;
    logic signed [XW-1:0]          top_temp_reg, top_temp_next;
    logic                          found_reg, found_next;
    logic [HEIGHT_BITS-1:0]        hlo_reg, hlo_next;
    logic signed [DW-1:0]          tdiff_reg, tdiff_next;
    logic signed [HEIGHT_BITS:0]   dh_reg, dh_next;
    logic signed [TEMP_BITS:0]     dt_reg, dt_next;

    logic                          accept;
    logic signed [XW-1:0]          tt_x, miss_x, t_x, prev_x;
    logic                          below_ok, above_ok, straddle;
    logic [HEIGHT_BITS-1:0]        clamp_h;

    assign in_ready = job_ready;
    assign accept   = in_valid & in_ready;

    assign tt_x   = XW'(target_temp);
    assign miss_x = XW'(missing_temp);
    assign t_x    = XW'(level_temp);
    assign prev_x = XW'(prev_temp_reg);

    assign below_ok = (prev_x != miss_x);
    assign above_ok = (t_x != miss_x);
    assign straddle = ((prev_x >= tt_x) && (t_x <= tt_x)) || ((prev_x <= tt_x) && (t_x >= tt_x));

    always_comb
    begin
        first_next      = first_reg;
        bot_height_next = bot_height_reg;
        bot_temp_next   = bot_temp_reg;
        top_temp_next   = top_temp_reg;
        found_next      = found_reg;
        hlo_next        = hlo_reg;
        tdiff_next      = tdiff_reg;
        dh_next         = dh_reg;
        dt_next         = dt_reg;
        if (accept)
        begin
            first_next = last_level;
            if (first_reg)
            begin
                bot_height_next = level_height;
                bot_temp_next   = miss_x;
                top_temp_next   = miss_x;
                found_next      = 1'b0;
            end
            else
            begin
                if (below_ok && (bot_temp_reg == miss_x))
                begin
                    bot_temp_next = prev_x;
                end
                if (above_ok)
                begin
                    top_temp_next = t_x;
                end
                // first straddling pair of the column wins
                if (!found_reg && below_ok && above_ok && straddle)
                begin
                    found_next = 1'b1;
                    hlo_next   = prev_height_reg;
                    tdiff_next = DW'(tt_x) - DW'(prev_x);
                    dh_next    = $signed({1'b0, level_height}) - $signed({1'b0, prev_height_reg});
                    dt_next    = (TEMP_BITS+1)'(level_temp) - (TEMP_BITS+1)'(prev_temp_reg);
                end
            end
        end
    end

    always_comb
    begin
        if (tt_x >= bot_temp_next)
        begin
            clamp_h = bot_height_next;
        end
        else if (tt_x <= top_temp_next)
        begin
            clamp_h = level_height;
        end
        else
        begin
            clamp_h = bot_height_next;
        end
    end

    assign job_valid = accept & last_level;
    assign job_data  = found_next ? {1'b1, hlo_next, tdiff_next, dh_next, dt_next}
                                  : {1'b0, clamp_h, {(JW-1-HEIGHT_BITS){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg       <= 1'b1;
            prev_temp_reg   <= '0;
            prev_height_reg <= '0;
            bot_height_reg  <= '0;
            bot_temp_reg    <= XW'(-(2 ** (ihf_pkg::MISSING_BITS - 1)));
            top_temp_reg    <= XW'(-(2 ** (ihf_pkg::MISSING_BITS - 1)));
            found_reg       <= 1'b0;
        end
        else
        begin
            first_reg      <= first_next;
            bot_height_reg <= bot_height_next;
            bot_temp_reg   <= bot_temp_next;
            top_temp_reg   <= top_temp_next;
            found_reg      <= found_next;
            if (accept)
            begin
                prev_temp_reg   <= level_temp;
                prev_height_reg <= level_height;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hlo_reg   <= hlo_next;
        tdiff_reg <= tdiff_next;
        dh_reg    <= dh_next;
        dt_reg    <= dt_next;
    end

endmodule

`default_nettype wire

>>> hdl/ihf_queue.sv
// small job fifo between front and back ends
// depends on ihf_pkg for the default depth
`default_nettype none

module ihf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ihf_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    // depth is a power of two, at least 2
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ihf_back.sv
// back end: multiply, restoring divide and final add, output register
// depends on ihf_pkg
`default_nettype none

module ihf_back #(
    parameter int TEMP_BITS   = ihf_pkg::TEMP_BITS_DEF,
    parameter int HEIGHT_BITS = ihf_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   job_valid,
    output logic                        job_ready,
    input  wire logic [ihf_pkg::job_bits(TEMP_BITS, HEIGHT_BITS)-1:0] job_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [HEIGHT_BITS-1:0]      isotherm_height,
    output logic                        crossing_found
);

    localparam int H  = HEIGHT_BITS;
    localparam int XW = ihf_pkg::ext_bits(TEMP_BITS);
    localparam int DW = XW + 1;
    localparam int PW = DW + H + 1;
    localparam int CW = $clog2(H);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [H-1:0]              hlo_reg, hlo_next;
    logic signed [DW-1:0]      tdiff_reg, tdiff_next;
    logic signed [H:0]         dh_reg, dh_next;
    logic signed [TEMP_BITS:0] dt_reg, dt_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic                      neg_reg, neg_next;
    logic [PW-1:0]             rem_reg, rem_next;
    logic [PW-1:0]             div_reg, div_next;
    logic [H-1:0]              q_reg, q_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [H-1:0]              out_height_reg, out_height_next;
    logic                      out_found_reg, out_found_next;

    logic                      job_found;
    logic [H-1:0]              job_hlo;
    logic signed [DW-1:0]      job_tdiff;
    logic signed [H:0]         job_dh;
    logic signed [TEMP_BITS:0] job_dt;
    logic                      out_free;
    logic [TEMP_BITS:0]        abs_dt;
    logic                      ge;
    logic [H-1:0]              q_signed;

    assign {job_found, job_hlo, job_tdiff, job_dh, job_dt} = job_data;

    assign out_free  = !out_valid_reg || out_ready;
    assign abs_dt    = dt_reg[TEMP_BITS] ? (TEMP_BITS+1)'(-dt_reg) : dt_reg;
    assign ge        = (rem_reg >= div_reg);
    assign prod_next = tdiff_reg * dh_reg;
    assign q_signed  = neg_reg ? (~q_reg + 1'b1) : q_reg;

    always_comb
    begin
        state_next      = state_reg;
        hlo_next        = hlo_reg;
        tdiff_next      = tdiff_reg;
        dh_next         = dh_reg;
        dt_next         = dt_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_height_next = out_height_reg;
        out_found_next  = out_found_reg;
        job_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_found)
                begin
                    job_ready  = 1'b1;
                    hlo_next   = job_hlo;
                    tdiff_next = job_tdiff;
                    dh_next    = job_dh;
                    dt_next    = job_dt;
                    state_next = ST_MUL;
                end
                else if (job_valid && out_free)
                begin
                    // clamped column goes straight to the output
                    job_ready       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_height_next = job_hlo;
                    out_found_next  = 1'b0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                rem_next = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
                div_next = PW'(abs_dt) << (H - 1);
                neg_next = prod_reg[PW-1] ^ dt_reg[TEMP_BITS];
                q_next   = '0;
                cnt_next = CW'(H - 1);
                if (dt_reg == '0)
                begin
                    // flat step: result is the lower height
                    rem_next   = '0;
                    neg_next   = 1'b0;
                    state_next = ST_ADD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? (rem_reg - div_reg) : rem_reg;
                q_next   = {q_reg[H-2:0], ge};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_height_next = hlo_reg + q_signed;
                    out_found_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hlo_reg        <= hlo_next;
        tdiff_reg      <= tdiff_next;
        dh_reg         <= dh_next;
        dt_reg         <= dt_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        q_reg          <= q_next;
        cnt_reg        <= cnt_next;
        out_height_reg <= out_height_next;
        out_found_reg  <= out_found_next;
    end

    assign out_valid       = out_valid_reg;
    assign isotherm_height = out_height_reg;
    assign crossing_found  = out_found_reg;

    // the divider is only entered with a nonzero step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dt_reg != '0))
        else $error("divider running with zero temperature step");

    // restoring invariant: partial remainder below twice the shifted divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < (div_reg << 1)))
        else $error("quotient overflow in divider");

    // final remainder is smaller than the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ADD) && (dt_reg != '0)) |-> (rem_reg < PW'(abs_dt)))
        else $error("divider finished with remainder not reduced");

    // divider hands over to the final add once its step counter reaches zero
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg == '0)) |=> (state_reg == ST_ADD))
        else $error("divider did not hand over to the final add");

endmodule

`default_nettype wire
